// ===== rtl/mbk_pkg.sv =====
package mbk_pkg;

    // Sizing
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_BATCH    = 1024;

    localparam int CLU_W   = $clog2(MAX_CLUSTERS);
    localparam int DIM_W   = $clog2(MAX_DIMS);
    localparam int CNT_W   = 32;
    localparam int BCNT_W  = 11;
    localparam int SUM_W   = 26;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 35;
    localparam int PROD_W  = 49;
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 33;
    localparam int REM_W   = 52;
    localparam int DVS_W   = 34;
    localparam int QUO_W   = 17;
    localparam int QBIT_W  = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_CLU_W  = 5;
    localparam int CFG_DIM_W  = 4;
    localparam int CFG_BS_W   = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH    = 2'd2;

    // Request kinds
    localparam logic [2:0] KIND_LOAD     = 3'd0;
    localparam logic [2:0] KIND_TRAIN    = 3'd1;
    localparam logic [2:0] KIND_FLUSH    = 3'd2;
    localparam logic [2:0] KIND_CLASSIFY = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    typedef logic signed [15:0] coord_t;
    typedef coord_t [MAX_DIMS-1:0] coord_row_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [MAX_DIMS-1:0] sum_row_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] center_index;
        coord_t     coord_0;
        coord_t     coord_1;
        coord_t     coord_2;
        coord_t     coord_3;
        coord_t     coord_4;
        coord_t     coord_5;
        coord_t     coord_6;
        coord_t     coord_7;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        nearest_cluster;
        logic [DIST_W-1:0] nearest_distance;
        coord_t            out_coord_0;
        coord_t            out_coord_1;
        coord_t            out_coord_2;
        coord_t            out_coord_3;
        coord_t            out_coord_4;
        coord_t            out_coord_5;
        coord_t            out_coord_6;
        coord_t            out_coord_7;
        logic [1:0]        status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic              capture;
        logic              ctr_rd;
        logic              ctr_load;
        logic              sum_rd;
        logic              sum_acc;
        logic              sq;
        logic              acc;
        logic              acc_first;
        logic              rd_cap;
        logic              upd_lat;
        logic              upd_mul;
        logic              upd_prep;
        logic              div_step;
        logic              upd_store;
        logic              upd_wr;
        logic              batch_clr;
        logic              res_load;
        logic [1:0]        status;
        logic [CLU_W-1:0]  addr;
        logic [DIM_W-1:0]  dim;
        logic [QBIT_W-1:0] qbit;
    } mbk_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0]           kind;
        logic                 idx_ok;
        logic [CLU_W-1:0]     idx;
        logic [CLU_W-1:0]     best;
        logic [CFG_CLU_W-1:0] nclu;
        logic                 fill_full;
        logic                 fill_zero;
        logic                 cnt_nz;
    } mbk_stat_t;

    function automatic coord_row_t item_coords(input in_item_t it);
        coord_row_t r;
        r[0] = it.coord_0;
        r[1] = it.coord_1;
        r[2] = it.coord_2;
        r[3] = it.coord_3;
        r[4] = it.coord_4;
        r[5] = it.coord_5;
        r[6] = it.coord_6;
        r[7] = it.coord_7;
        return r;
    endfunction

endpackage

// ===== rtl/mini_batch_kmeans_engine.sv =====
// Mini-batch k-means engine with up to 16 centers of 8 signed Q8.8
// coordinates. One request is worked at a time; in_ready is high only
// while the engine is idle, and a finished result sits in an output
// register so the next request can be taken before it is drained. Steps
// per request: a load writes one center row; a read reads one row and
// captures it; classify reads, squares, sums and compares one active
// center row in turn; train does that and then folds the point into its
// cluster's batch sums. A center update (batch full, or flush of a
// non-empty batch) walks all 16 clusters: an untouched one is skipped,
// and for one that received points each of its 8 coordinates goes through
// a multiply, a prepare step and a 17-step restoring divider; the batch is
// then cleared. No clearing pass after reset: unwritten rows read as zero
// through per-row valid bits. Configuration writes are always taken and
// must be issued only while the engine is idle.
module mini_batch_kmeans_engine import mbk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mbk_cmd_t  cmd;
    mbk_stat_t stat;

    // Configuration never stalls
    assign cfg_ready = 1'b1;

    mbk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mbk_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/mbk_datapath.sv =====
module mbk_datapath import mbk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_item,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  mbk_cmd_t              cmd,
    output mbk_stat_t             stat,
    output out_item_t             out_item
);

    logic [CFG_CLU_W-1:0] clu_cfg_reg;
    logic [CFG_DIM_W-1:0] dim_cfg_reg;
    logic [CFG_BS_W-1:0]  bs_cfg_reg;
    logic [CFG_CLU_W-1:0] nclu;
    logic [CFG_DIM_W-1:0] nd;
    logic [CFG_BS_W-1:0]  bs;

    in_item_t   item_reg;
    coord_row_t pt;

    coord_row_t                  ctr_mem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]     ctr_vld_reg;
    coord_row_t                  ctr_rdata_reg;
    logic                        ctr_rvld_reg;
    coord_row_t                  ctr_row;
    logic                        ctr_wr;
    coord_row_t                  ctr_wdata;

    sum_row_t                    sum_mem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]     sum_vld_reg;
    sum_row_t                    sum_rdata_reg;
    logic                        sum_rvld_reg;
    sum_row_t                    sum_row;
    sum_row_t                    sum_wdata;

    logic [CNT_W-1:0]  cum_cnt_reg [MAX_CLUSTERS];
    logic [BCNT_W-1:0] bcnt_reg [MAX_CLUSTERS];
    logic [BCNT_W-1:0] fill_reg;

    logic [SQ_W-1:0]   sq_reg [MAX_DIMS];
    logic [SQ_W-1:0]   sq_next [MAX_DIMS];
    logic [DIST_W-1:0] dist_sum;
    logic [DIST_W-1:0] best_dist_reg;
    logic [CLU_W-1:0]  best_reg;

    coord_row_t               work_row_reg;
    sum_row_t                 work_sum_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DEN_W-1:0]  n_s;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         mag;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         shifted;
    logic [DVS_W-1:0]         dvs_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic                     neg_reg;
    coord_t                   st_val;

    coord_row_t rd_row_reg;
    out_item_t  out_reg;
    out_item_t  out_next;

    // Clamp registers into range on use
    always_comb
    begin
        if (clu_cfg_reg == '0)
            nclu = CFG_CLU_W'(1);
        else if (clu_cfg_reg > CFG_CLU_W'(MAX_CLUSTERS))
            nclu = CFG_CLU_W'(MAX_CLUSTERS);
        else
            nclu = clu_cfg_reg;

        if (dim_cfg_reg == '0)
            nd = CFG_DIM_W'(1);
        else if (dim_cfg_reg > CFG_DIM_W'(MAX_DIMS))
            nd = CFG_DIM_W'(MAX_DIMS);
        else
            nd = dim_cfg_reg;

        if (bs_cfg_reg == '0)
            bs = CFG_BS_W'(1);
        else if (bs_cfg_reg > CFG_BS_W'(MAX_BATCH))
            bs = CFG_BS_W'(MAX_BATCH);
        else
            bs = bs_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clu_cfg_reg <= CFG_CLU_W'(16);
            dim_cfg_reg <= CFG_DIM_W'(8);
            bs_cfg_reg  <= CFG_BS_W'(1024);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_CLUSTERS: clu_cfg_reg <= cfg_data[CFG_CLU_W-1:0];
                CFG_DIMS:     dim_cfg_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_BATCH:    bs_cfg_reg  <= cfg_data[CFG_BS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
    end

    assign pt = item_coords(item_reg);

    // Center store: one row per cluster, rows never written read as zero
    assign ctr_wr    = cmd.ctr_load | cmd.upd_wr;
    assign ctr_wdata = cmd.ctr_load ? pt : work_row_reg;
    assign ctr_row   = ctr_rvld_reg ? ctr_rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        if (ctr_wr)
            ctr_mem[cmd.addr] <= ctr_wdata;
        if (cmd.ctr_rd)
            ctr_rdata_reg <= ctr_mem[cmd.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_vld_reg  <= '0;
            ctr_rvld_reg <= 1'b0;
        end
        else
        begin
            if (ctr_wr)
                ctr_vld_reg[cmd.addr] <= 1'b1;
            if (cmd.ctr_rd)
                ctr_rvld_reg <= ctr_vld_reg[cmd.addr];
        end
    end

    // Batch sums: row valid bits drop on batch clear
    assign sum_row = sum_rvld_reg ? sum_rdata_reg : '0;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
            sum_wdata[d] = sum_row[d] + {{(SUM_W-16){pt[d][15]}}, pt[d]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_acc)
            sum_mem[cmd.addr] <= sum_wdata;
        if (cmd.sum_rd)
            sum_rdata_reg <= sum_mem[cmd.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg  <= '0;
            sum_rvld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.batch_clr)
                sum_vld_reg <= '0;
            else if (cmd.sum_acc)
                sum_vld_reg[cmd.addr] <= 1'b1;
            if (cmd.sum_rd)
                sum_rvld_reg <= sum_vld_reg[cmd.addr];
        end
    end

    // Counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < MAX_CLUSTERS; g++)
            begin
                cum_cnt_reg[g] <= '0;
                bcnt_reg[g]    <= '0;
            end
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.ctr_load)
                cum_cnt_reg[cmd.addr] <= '0;
            else if (cmd.upd_wr)
                cum_cnt_reg[cmd.addr] <= den_reg[DEN_W-1] ? '1 : den_reg[CNT_W-1:0];

            if (cmd.batch_clr)
            begin
                for (int g = 0; g < MAX_CLUSTERS; g++)
                    bcnt_reg[g] <= '0;
                fill_reg <= '0;
            end
            else if (cmd.sum_acc)
            begin
                bcnt_reg[cmd.addr] <= bcnt_reg[cmd.addr] + BCNT_W'(1);
                fill_reg           <= fill_reg + BCNT_W'(1);
            end
        end
    end

    // Distance: squares per lane, then sum and compare
    always_comb
    begin
        logic signed [16:0] diff;
        logic signed [33:0] sqw;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            diff = 17'(pt[d]) - 17'(ctr_row[d]);
            sqw  = diff * diff;
            sq_next[d] = (CFG_DIM_W'(d) < nd) ? sqw[SQ_W-1:0] : '0;
        end
    end

    always_comb
    begin
        dist_sum = '0;
        for (int d = 0; d < MAX_DIMS; d++)
            dist_sum = dist_sum + DIST_W'(sq_reg[d]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq)
            sq_reg <= sq_next;
        if (cmd.acc && (cmd.acc_first || dist_sum < best_dist_reg))
        begin
            best_dist_reg <= dist_sum;
            best_reg      <= cmd.addr;
        end
    end

    // Center update: (n*old + sum) / (n + k), one quotient bit per step
    assign n_s       = $signed({1'b0, n_reg});
    assign prod_next = n_s * work_row_reg[cmd.dim];
    assign num       = prod_reg + work_sum_reg[cmd.dim];
    assign mag       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign shifted   = REM_W'(dvs_reg) << cmd.qbit;

    always_comb
    begin
        if (!neg_reg)
            st_val = (quo_reg > QUO_W'(32767)) ? 16'sh7FFF : coord_t'(quo_reg[15:0]);
        else
            st_val = (quo_reg >= QUO_W'(32768)) ? 16'sh8000
                                                : coord_t'(~quo_reg[15:0] + 16'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_lat)
        begin
            work_row_reg <= ctr_row;
            work_sum_reg <= sum_row;
            n_reg        <= cum_cnt_reg[cmd.addr];
            den_reg      <= DEN_W'(cum_cnt_reg[cmd.addr]) + DEN_W'(bcnt_reg[cmd.addr]);
        end
        else if (cmd.upd_store)
            work_row_reg[cmd.dim] <= st_val;

        if (cmd.upd_mul)
            prod_reg <= prod_next;

        if (cmd.upd_prep)
        begin
            rem_reg <= REM_W'({mag, 1'b0}) + REM_W'(den_reg);
            dvs_reg <= {den_reg, 1'b0};
            quo_reg <= '0;
            neg_reg <= num[NUM_W-1];
        end
        else if (cmd.div_step && rem_reg >= shifted)
        begin
            rem_reg           <= rem_reg - shifted;
            quo_reg[cmd.qbit] <= 1'b1;
        end

        if (cmd.rd_cap)
            rd_row_reg <= ctr_row;
    end

    // Result
    always_comb
    begin
        out_next        = '0;
        out_next.status = cmd.status;
        if (cmd.status != ST_REJECT)
        begin
            if (item_reg.kind inside {KIND_TRAIN, KIND_CLASSIFY})
            begin
                out_next.nearest_cluster  = 4'(best_reg);
                out_next.nearest_distance = best_dist_reg;
            end
            else if (item_reg.kind == KIND_READ)
            begin
                out_next.out_coord_0 = rd_row_reg[0];
                out_next.out_coord_1 = rd_row_reg[1];
                out_next.out_coord_2 = rd_row_reg[2];
                out_next.out_coord_3 = rd_row_reg[3];
                out_next.out_coord_4 = rd_row_reg[4];
                out_next.out_coord_5 = rd_row_reg[5];
                out_next.out_coord_6 = rd_row_reg[6];
                out_next.out_coord_7 = rd_row_reg[7];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
            out_reg <= out_next;
    end

    assign out_item = out_reg;

    assign stat.kind      = item_reg.kind;
    assign stat.idx_ok    = {1'b0, item_reg.center_index} < 5'(MAX_CLUSTERS);
    assign stat.idx       = item_reg.center_index[CLU_W-1:0];
    assign stat.best      = best_reg;
    assign stat.nclu      = nclu;
    assign stat.fill_full = (12'(fill_reg) + 12'd1) >= 12'(bs);
    assign stat.fill_zero = (fill_reg == '0);
    assign stat.cnt_nz    = (bcnt_reg[cmd.addr] != '0);

endmodule

// ===== rtl/mbk_ctrl.sv =====
module mbk_ctrl import mbk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  mbk_stat_t stat,
    output mbk_cmd_t  cmd
);

    typedef enum logic [19:0] {
        S_IDLE  = 20'b00000000000000000001,
        S_DISP  = 20'b00000000000000000010,
        S_LOAD  = 20'b00000000000000000100,
        S_RD    = 20'b00000000000000001000,
        S_RDCAP = 20'b00000000000000010000,
        S_SRD   = 20'b00000000000000100000,
        S_SSQ   = 20'b00000000000001000000,
        S_SACC  = 20'b00000000000010000000,
        S_ARD   = 20'b00000000000100000000,
        S_AWR   = 20'b00000000001000000000,
        S_UCHK  = 20'b00000000010000000000,
        S_URD   = 20'b00000000100000000000,
        S_ULAT  = 20'b00000001000000000000,
        S_UMUL  = 20'b00000010000000000000,
        S_UPREP = 20'b00000100000000000000,
        S_UDIV  = 20'b00001000000000000000,
        S_USTO  = 20'b00010000000000000000,
        S_UWR   = 20'b00100000000000000000,
        S_UCLR  = 20'b01000000000000000000,
        S_FIN   = 20'b10000000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CLU_W-1:0]  cnt_reg, cnt_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [QBIT_W-1:0] qbit_reg, qbit_next;
    logic [1:0]        status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_active;

    assign last_active = (CFG_CLU_W'(cnt_reg) + CFG_CLU_W'(1)) == stat.nclu;

    always_comb
    begin
        cmd            = '0;
        cmd.addr       = cnt_reg;
        cmd.dim        = dim_reg;
        cmd.qbit       = qbit_reg;
        cmd.status     = status_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dim_next       = dim_reg;
        qbit_next      = qbit_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    status_next = ST_DONE;
                    cnt_next    = '0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.kind)
                    KIND_LOAD:
                    begin
                        if (stat.idx_ok)
                            state_next = S_LOAD;
                        else
                        begin
                            status_next = ST_REJECT;
                            state_next  = S_FIN;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.idx_ok)
                            state_next = S_RD;
                        else
                        begin
                            status_next = ST_REJECT;
                            state_next  = S_FIN;
                        end
                    end
                    KIND_TRAIN, KIND_CLASSIFY:
                        state_next = S_SRD;
                    KIND_FLUSH:
                    begin
                        if (stat.fill_zero)
                            state_next = S_FIN;
                        else
                        begin
                            status_next = ST_UPDATED;
                            state_next  = S_UCHK;
                        end
                    end
                    default:
                    begin
                        status_next = ST_REJECT;
                        state_next  = S_FIN;
                    end
                endcase
            end
            S_LOAD:
            begin
                cmd.addr     = stat.idx;
                cmd.ctr_load = 1'b1;
                state_next   = S_FIN;
            end
            S_RD:
            begin
                cmd.addr   = stat.idx;
                cmd.ctr_rd = 1'b1;
                state_next = S_RDCAP;
            end
            S_RDCAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = S_FIN;
            end
            S_SRD:
            begin
                cmd.ctr_rd = 1'b1;
                state_next = S_SSQ;
            end
            S_SSQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_SACC;
            end
            S_SACC:
            begin
                cmd.acc       = 1'b1;
                cmd.acc_first = (cnt_reg == '0);
                if (last_active)
                    state_next = (stat.kind == KIND_TRAIN) ? S_ARD : S_FIN;
                else
                begin
                    cnt_next   = cnt_reg + CLU_W'(1);
                    state_next = S_SRD;
                end
            end
            S_ARD:
            begin
                cmd.addr   = stat.best;
                cmd.sum_rd = 1'b1;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.addr    = stat.best;
                cmd.sum_acc = 1'b1;
                if (stat.fill_full)
                begin
                    status_next = ST_UPDATED;
                    cnt_next    = '0;
                    state_next  = S_UCHK;
                end
                else
                    state_next = S_FIN;
            end
            S_UCHK:
            begin
                if (stat.cnt_nz)
                    state_next = S_URD;
                else if (cnt_reg == CLU_W'(MAX_CLUSTERS - 1))
                    state_next = S_UCLR;
                else
                    cnt_next = cnt_reg + CLU_W'(1);
            end
            S_URD:
            begin
                cmd.ctr_rd = 1'b1;
                cmd.sum_rd = 1'b1;
                state_next = S_ULAT;
            end
            S_ULAT:
            begin
                cmd.upd_lat = 1'b1;
                dim_next    = '0;
                state_next  = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.upd_mul = 1'b1;
                state_next  = S_UPREP;
            end
            S_UPREP:
            begin
                cmd.upd_prep = 1'b1;
                qbit_next    = QBIT_W'(QUO_W - 1);
                state_next   = S_UDIV;
            end
            S_UDIV:
            begin
                cmd.div_step = 1'b1;
                if (qbit_reg == '0)
                    state_next = S_USTO;
                else
                    qbit_next = qbit_reg - QBIT_W'(1);
            end
            S_USTO:
            begin
                cmd.upd_store = 1'b1;
                if (dim_reg == DIM_W'(MAX_DIMS - 1))
                    state_next = S_UWR;
                else
                begin
                    dim_next   = dim_reg + DIM_W'(1);
                    state_next = S_UMUL;
                end
            end
            S_UWR:
            begin
                cmd.upd_wr = 1'b1;
                if (cnt_reg == CLU_W'(MAX_CLUSTERS - 1))
                    state_next = S_UCLR;
                else
                begin
                    cnt_next   = cnt_reg + CLU_W'(1);
                    state_next = S_UCHK;
                end
            end
            S_UCLR:
            begin
                cmd.batch_clr = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dim_reg       <= '0;
            qbit_reg      <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dim_reg       <= dim_next;
            qbit_reg      <= qbit_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/mbk_checker.sv =====
module mbk_checker import mbk_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input in_item_t              in_item,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_item,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // One request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status != 2'd3)
        else $error("undefined status code");

    // Rejected requests carry nothing but their status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_REJECT |->
            out_item.nearest_cluster == '0 && out_item.nearest_distance == '0 &&
            out_item.out_coord_0 == '0)
        else $error("rejected result carries data");

endmodule

bind mini_batch_kmeans_engine mbk_checker u_mbk_checker (.*);
